// File: hw/rtl/aue_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aue_pkg
// Shared constants, types and helpers of the Adam element update pipeline.
// ----------------------------------------------------------------------------
package aue_pkg;

  // Configuration port.
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_STEP  = 3'd0;
  localparam logic [2:0] REG_BETA1 = 3'd1;
  localparam logic [2:0] REG_BETA2 = 3'd2;
  localparam logic [2:0] REG_DECAY = 3'd3;
  localparam logic [2:0] REG_EPS   = 3'd4;

  localparam logic [30:0] RST_STEP  = 31'd16777;
  localparam logic [30:0] RST_BETA1 = 31'd1932735283;
  localparam logic [30:0] RST_BETA2 = 31'd2145336164;
  localparam logic [30:0] RST_DECAY = 31'd2147483626;
  localparam logic [24:0] RST_EPS   = 25'd1;

  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
  localparam logic [30:0] MAX31   = 31'h7FFF_FFFF;

  // Radix-2 divider pipeline: one quotient bit per stage.
  localparam int DIV_N_W = 63;
  localparam int DIV_D_W = 32;
  localparam int DIV_LAT = DIV_N_W;

  // Square root pipeline: one root bit per stage.
  localparam int SQRT_W   = 56;
  localparam int SQRT_R_W = SQRT_W / 2;
  localparam int SQRT_LAT = SQRT_R_W;

  // Stage count from input register to output register.
  localparam int PIPE_N = 9 + 2 * DIV_LAT + SQRT_LAT;

  // Data that rides along the pipeline beside the arithmetic.
  typedef struct packed {
    logic               last;
    logic [30:0]        nd1;
    logic [30:0]        np1;
    logic [30:0]        np2;
    logic signed [31:0] param;
    logic signed [31:0] new_m;
    logic [30:0]        new_v;
  } side_t;

  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/aue_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aue_in_if
// Input channel: one vector element with its moments and decay terms.
// ----------------------------------------------------------------------------
interface aue_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] gain_factor;
  logic signed [31:0] gradient;
  logic signed [31:0] first_moment;
  logic [30:0]        second_moment;
  logic signed [31:0] param_value;
  logic [30:0]        decayed_beta_one;
  logic [30:0]        beta_one_power;
  logic [30:0]        beta_two_power;
  logic               last_element;

  modport source (
    output valid, gain_factor, gradient, first_moment, second_moment, param_value,
    output decayed_beta_one, beta_one_power, beta_two_power, last_element,
    input  ready
  );
  modport sink (
    input  valid, gain_factor, gradient, first_moment, second_moment, param_value,
    input  decayed_beta_one, beta_one_power, beta_two_power, last_element,
    output ready
  );
endinterface
`default_nettype wire

// File: hw/rtl/aue_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aue_out_if
// Output channel: updated element and forwarded decay terms.
// ----------------------------------------------------------------------------
interface aue_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_first_moment;
  logic [30:0]        new_second_moment;
  logic signed [31:0] new_param_value;
  logic [30:0]        next_decayed_beta_one;
  logic [30:0]        next_beta_one_power;
  logic [30:0]        next_beta_two_power;
  logic               last_out;

  modport source (
    output valid, new_first_moment, new_second_moment, new_param_value,
    output next_decayed_beta_one, next_beta_one_power, next_beta_two_power, last_out,
    input  ready
  );
  modport sink (
    input  valid, new_first_moment, new_second_moment, new_param_value,
    input  next_decayed_beta_one, next_beta_one_power, next_beta_two_power, last_out,
    output ready
  );
endinterface
`default_nettype wire

// File: hw/rtl/adam_update_element_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adam_update_element_core
// Fixed-point Adam update of one vector element per transfer.
// ----------------------------------------------------------------------------
// The core takes one element per clock while no finished result waits to be
// taken, and returns one result per element, in order. Data passes through
// 63-stage divider pipelines for bias correction (two side by side) and then
// for step over root, a 28-stage square root pipeline between them, and nine
// arithmetic stages around them. All stages advance together and freeze while
// a finished result waits to be taken, so input and output may stall in any pattern.
module adam_update_element_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [aue_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  aue_in_if.sink                      item,
  aue_out_if.source                   result
);
  import aue_pkg::*;

  // Configuration registers.
  logic [30:0] step_size;
  logic [30:0] beta_one;
  logic [30:0] beta_two;
  logic [30:0] beta_one_decay;
  logic [24:0] epsilon;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size      <= RST_STEP;
      beta_one       <= RST_BETA1;
      beta_two       <= RST_BETA2;
      beta_one_decay <= RST_DECAY;
      epsilon        <= RST_EPS;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_STEP:  step_size      <= pwdata[30:0];
        REG_BETA1: beta_one       <= pwdata[30:0];
        REG_BETA2: beta_two       <= pwdata[30:0];
        REG_DECAY: beta_one_decay <= pwdata[30:0];
        REG_EPS:   epsilon        <= pwdata[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_STEP:  prdata = {1'b0, step_size};
      REG_BETA1: prdata = {1'b0, beta_one};
      REG_BETA2: prdata = {1'b0, beta_two};
      REG_DECAY: prdata = {1'b0, beta_one_decay};
      REG_EPS:   prdata = {7'd0, epsilon};
      default:   prdata = '0;
    endcase
  end

  // Pipeline control: every stage moves when the output register is free.
  logic              en;
  logic [PIPE_N-1:0] vld;

  assign en         = !vld[PIPE_N-1] || result.ready;
  assign item.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_N-2:0], item.valid};
    end
  end

  // Stage 1: gain times gradient, decay products.
  logic signed [63:0] s1_gg;
  logic [61:0]        s1_pd1, s1_pp1, s1_pp2;
  logic signed [31:0] s1_m, s1_param;
  logic [30:0]        s1_v, s1_b1t, s1_p1, s1_p2;
  logic               s1_last;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_gg    <= item.gain_factor * item.gradient;
      s1_pd1   <= 62'(item.decayed_beta_one) * 62'(beta_one_decay);
      s1_pp1   <= 62'(item.beta_one_power) * 62'(beta_one);
      s1_pp2   <= 62'(item.beta_two_power) * 62'(beta_two);
      s1_m     <= item.first_moment;
      s1_param <= item.param_value;
      s1_v     <= item.second_moment;
      s1_b1t   <= item.decayed_beta_one;
      s1_p1    <= item.beta_one_power;
      s1_p2    <= item.beta_two_power;
      s1_last  <= item.last_element;
    end
  end

  // Stage 2: scaled gradient in Q8.24.
  logic signed [31:0] s2_gs, s2_m;
  logic [30:0]        s2_v, s2_b1t, s2_p1, s2_p2;
  side_t              s2_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_gs   <= sat32(66'(s1_gg >>> 24));
      s2_m    <= s1_m;
      s2_v    <= s1_v;
      s2_b1t  <= s1_b1t;
      s2_p1   <= s1_p1;
      s2_p2   <= s1_p2;
      s2_side <= '{last: s1_last, nd1: s1_pd1[61:31], np1: s1_pp1[61:31],
                   np2: s1_pp2[61:31], param: s1_param, new_m: '0, new_v: '0};
    end
  end

  // Stage 3: first moment blend products and gradient square.
  logic [31:0]        w1;
  logic signed [63:0] s3_pm1, s3_psq;
  logic signed [64:0] s3_pm2;
  logic [30:0]        s3_v, s3_p1, s3_p2;
  side_t              s3_side;

  assign w1 = ONE_Q31 - {1'b0, s2_b1t};

  always_ff @(posedge clk) begin
    if (en) begin
      s3_pm1  <= $signed({1'b0, s2_b1t}) * s2_m;
      s3_pm2  <= $signed({1'b0, w1}) * s2_gs;
      s3_psq  <= s2_gs * s2_gs;
      s3_v    <= s2_v;
      s3_p1   <= s2_p1;
      s3_p2   <= s2_p2;
      s3_side <= s2_side;
    end
  end

  // Stage 4: new first moment, saturated square.
  logic signed [65:0] m_sum;
  logic [39:0]        sq_full;
  logic [30:0]        s4_sq, s4_v, s4_p1, s4_p2;
  side_t              s4_side;
  side_t              s4_side_next;

  assign m_sum   = 66'(s3_pm1) + 66'(s3_pm2);
  assign sq_full = s3_psq[63:24];

  always_comb begin
    s4_side_next       = s3_side;
    s4_side_next.new_m = sat32(m_sum >>> 31);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sq   <= (sq_full > 40'(MAX31)) ? MAX31 : sq_full[30:0];
      s4_v    <= s3_v;
      s4_p1   <= s3_p1;
      s4_p2   <= s3_p2;
      s4_side <= s4_side_next;
    end
  end

  // Stage 5: second moment blend products.
  logic [31:0] w2;
  logic [61:0] s5_pv1;
  logic [62:0] s5_pv2;
  logic [30:0] s5_p1, s5_p2;
  side_t       s5_side;

  assign w2 = ONE_Q31 - {1'b0, beta_two};

  always_ff @(posedge clk) begin
    if (en) begin
      s5_pv1  <= 62'(beta_two) * 62'(s4_v);
      s5_pv2  <= 63'(w2) * 63'(s4_sq);
      s5_p1   <= s4_p1;
      s5_p2   <= s4_p2;
      s5_side <= s4_side;
    end
  end

  // Stage 6: new second moment.
  logic [63:0] v_sum;
  logic [30:0] s6_p1, s6_p2;
  side_t       s6_side;
  side_t       s6_side_next;

  assign v_sum = 64'(s5_pv1) + 64'(s5_pv2);

  always_comb begin
    s6_side_next       = s5_side;
    s6_side_next.new_v = (v_sum[63:31] > 33'(MAX31)) ? MAX31 : v_sum[61:31];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_p1   <= s5_p1;
      s6_p2   <= s5_p2;
      s6_side <= s6_side_next;
    end
  end

  // Bias correction: both divisions run side by side.
  logic [31:0]        abs_m;
  logic [DIV_N_W-1:0] qa, qb;

  assign abs_m = s6_side.new_m[31] ? 32'(-s6_side.new_m) : 32'(s6_side.new_m);

  aue_div u_div_m (
    .clk      (clk),
    .en       (en),
    .dividend ({abs_m, 31'd0}),
    .divisor  (ONE_Q31 - {1'b0, s6_p1}),
    .quotient (qa)
  );

  aue_div u_div_v (
    .clk      (clk),
    .en       (en),
    .dividend ({1'b0, s6_side.new_v, 31'd0}),
    .divisor  (ONE_Q31 - {1'b0, s6_p2}),
    .quotient (qb)
  );

  side_t side_ab [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      side_ab[0] <= s6_side;
      for (int i = 1; i < DIV_LAT; i++) begin
        side_ab[i] <= side_ab[i-1];
      end
    end
  end

  // Stage 7: saturate corrected moments, add epsilon.
  logic [DIV_N_W-1:0] mh_lim;
  logic [31:0]        s7_mh, s7_s;
  side_t              s7_side;

  assign mh_lim = side_ab[DIV_LAT-1].new_m[31] ? DIV_N_W'(ONE_Q31) : DIV_N_W'(MAX31);

  always_ff @(posedge clk) begin
    if (en) begin
      s7_mh   <= (qa > mh_lim) ? mh_lim[31:0] : qa[31:0];
      s7_s    <= 32'(epsilon) + ((qb > DIV_N_W'(MAX31)) ? 32'(MAX31) : 32'(qb[30:0]));
      s7_side <= side_ab[DIV_LAT-1];
    end
  end

  // Root of epsilon plus corrected second moment, in Q4.24.
  logic [SQRT_R_W-1:0] root;
  logic [31:0]         mh_sq   [SQRT_LAT];
  side_t               side_sq [SQRT_LAT];

  aue_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand ({s7_s, 24'd0}),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      mh_sq[0]   <= s7_mh;
      side_sq[0] <= s7_side;
      for (int i = 1; i < SQRT_LAT; i++) begin
        mh_sq[i]   <= mh_sq[i-1];
        side_sq[i] <= side_sq[i-1];
      end
    end
  end

  // Stage 8: step size times corrected first moment magnitude.
  logic [62:0]         s8_prod;
  logic [SQRT_R_W-1:0] s8_r;
  logic                s8_nz;
  side_t               s8_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_prod <= 63'(step_size) * 63'(mh_sq[SQRT_LAT-1]);
      s8_r    <= root;
      s8_nz   <= mh_sq[SQRT_LAT-1] != '0;
      s8_side <= side_sq[SQRT_LAT-1];
    end
  end

  logic [DIV_N_W-1:0] qc;
  logic               rz_c   [DIV_LAT];
  logic               nz_c   [DIV_LAT];
  side_t              side_c [DIV_LAT];

  aue_div u_div_step (
    .clk      (clk),
    .en       (en),
    .dividend (s8_prod),
    .divisor  (DIV_D_W'(s8_r)),
    .quotient (qc)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      rz_c[0]   <= s8_r == '0;
      nz_c[0]   <= s8_nz;
      side_c[0] <= s8_side;
      for (int i = 1; i < DIV_LAT; i++) begin
        rz_c[i]   <= rz_c[i-1];
        nz_c[i]   <= nz_c[i-1];
        side_c[i] <= side_c[i-1];
      end
    end
  end

  // Stage 9: apply the step. A magnitude of 2^33 already saturates any sum,
  // so the zero root case and large quotients clamp there.
  logic [33:0]        mag;
  logic signed [35:0] p_ext, m_ext, p_sum;
  side_t              fin;

  assign fin = side_c[DIV_LAT-1];

  always_comb begin
    if (rz_c[DIV_LAT-1]) begin
      mag = nz_c[DIV_LAT-1] ? 34'h2_0000_0000 : 34'd0;
    end else if (qc >= DIV_N_W'(34'h2_0000_0000)) begin
      mag = 34'h2_0000_0000;
    end else begin
      mag = qc[33:0];
    end
    p_ext = 36'(fin.param);
    m_ext = $signed({2'b00, mag});
    p_sum = fin.new_m[31] ? (p_ext - m_ext) : (p_ext + m_ext);
  end

  assign result.valid = vld[PIPE_N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      result.new_first_moment      <= fin.new_m;
      result.new_second_moment     <= fin.new_v;
      result.new_param_value       <= sat32(66'(p_sum));
      result.next_decayed_beta_one <= fin.nd1;
      result.next_beta_one_power   <= fin.np1;
      result.next_beta_two_power   <= fin.np2;
      result.last_out              <= fin.last;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/aue_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aue_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module aue_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [aue_pkg::DIV_N_W-1:0]  dividend,
  input  logic [aue_pkg::DIV_D_W-1:0]  divisor,
  output logic [aue_pkg::DIV_N_W-1:0]  quotient
);
  import aue_pkg::*;

  logic [DIV_D_W-1:0] rem [DIV_LAT];
  logic [DIV_N_W-1:0] num [DIV_LAT];
  logic [DIV_D_W-1:0] den [DIV_LAT];

  for (genvar i = 0; i < DIV_LAT; i++) begin : g_st
    logic [DIV_D_W-1:0] rin;
    logic [DIV_N_W-1:0] nin;
    logic [DIV_D_W-1:0] din;
    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   diff;
    logic               take;

    if (i == 0) begin : g_first
      assign rin = '0;
      assign nin = dividend;
      assign din = divisor;
    end else begin : g_next
      assign rin = rem[i-1];
      assign nin = num[i-1];
      assign din = den[i-1];
    end

    // The numerator register shifts its top bit out and takes the quotient bit in.
    assign trial = {rin, nin[DIV_N_W-1]};
    assign diff  = trial - {1'b0, din};
    assign take  = trial >= {1'b0, din};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= take ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
        num[i] <= {nin[DIV_N_W-2:0], take};
        den[i] <= din;
      end
    end
  end

  assign quotient = num[DIV_LAT-1];

endmodule
`default_nettype wire

// File: hw/rtl/aue_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aue_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module aue_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [aue_pkg::SQRT_W-1:0]    radicand,
  output logic [aue_pkg::SQRT_R_W-1:0]  root
);
  import aue_pkg::*;

  logic [SQRT_R_W+1:0] rem  [SQRT_LAT];
  logic [SQRT_R_W-1:0] rt   [SQRT_LAT];
  logic [SQRT_W-1:0]   rad  [SQRT_LAT];

  for (genvar i = 0; i < SQRT_LAT; i++) begin : g_st
    logic [SQRT_R_W+1:0] rin;
    logic [SQRT_R_W-1:0] tin;
    logic [SQRT_W-1:0]   ain;
    logic [SQRT_R_W+3:0] trial;
    logic [SQRT_R_W+3:0] cmp;
    logic [SQRT_R_W+3:0] diff;
    logic                take;

    if (i == 0) begin : g_first
      assign rin = '0;
      assign tin = '0;
      assign ain = radicand;
    end else begin : g_next
      assign rin = rem[i-1];
      assign tin = rt[i-1];
      assign ain = rad[i-1];
    end

    // Bring down two radicand bits and try the partial root times four plus one.
    assign trial = {rin, ain[SQRT_W-1:SQRT_W-2]};
    assign cmp   = {2'b00, tin, 2'b01};
    assign diff  = trial - cmp;
    assign take  = trial >= cmp;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= take ? diff[SQRT_R_W+1:0] : trial[SQRT_R_W+1:0];
        rt[i]  <= {tin[SQRT_R_W-2:0], take};
        rad[i] <= {ain[SQRT_W-3:0], 2'b00};
      end
    end
  end

  assign root = rt[SQRT_LAT-1];

endmodule
`default_nettype wire

// File: verif/adam_update_element_core_test.sv
// ----------------------------------------------------------------------------
// Adam element update core testbench
// Streams vector elements through the core under several register settings
// and checks every result against a fixed-point model of the Adam step.
// Both channels idle at random, and the result side stalls once for a long
// stretch so that the pipeline fills up.
// ----------------------------------------------------------------------------
module adam_update_element_core_test;
  import aue_pkg::*;

  typedef struct {
    logic signed [31:0] gain;
    logic signed [31:0] grad;
    logic signed [31:0] m;
    logic [30:0]        v;
    logic signed [31:0] param;
    logic [30:0]        b1t;
    logic [30:0]        p1;
    logic [30:0]        p2;
    logic               last;
  } element_t;

  typedef struct packed {
    logic signed [31:0] m;
    logic [30:0]        v;
    logic signed [31:0] param;
    logic [30:0]        nd1;
    logic [30:0]        np1;
    logic [30:0]        np2;
    logic               last;
  } update_t;

  localparam longint Q31 = 64'sh8000_0000;
  localparam longint HI32 = 64'sd2147483647;
  localparam longint LO32 = -64'sd2147483648;
  localparam longint M31 = 64'sh7FFF_FFFF;

  class adam_scoreboard;
    longint step, beta1, beta2, decay, eps;
    update_t pending[$];
    int errors;

    function new();
      step = RST_STEP;
      beta1 = RST_BETA1;
      beta2 = RST_BETA2;
      decay = RST_DECAY;
      eps = RST_EPS;
      errors = 0;
    endfunction

    function longint clamp32(longint x);
      if (x > HI32) return HI32;
      if (x < LO32) return LO32;
      return x;
    endfunction

    function longint root_floor(longint x);
      longint r, t;
      r = 0;
      for (int i = 28; i >= 0; i--) begin
        t = r | (64'sd1 << i);
        if (t * t <= x) r = t;
      end
      return r;
    endfunction

    function void note(element_t e);
      longint g, gr, m, v, pr, b1t, p1, p2;
      longint gs, nm, sq, nv, mh, vh, r, mag, np;
      update_t u;
      g = e.gain; gr = e.grad; m = e.m; pr = e.param;
      v = {33'd0, e.v}; b1t = {33'd0, e.b1t}; p1 = {33'd0, e.p1}; p2 = {33'd0, e.p2};
      gs = clamp32((g * gr) >>> 24);
      nm = clamp32((b1t * m + (Q31 - b1t) * gs) >>> 31);
      sq = (gs * gs) >>> 24;
      if (sq > M31) sq = M31;
      nv = (beta2 * v + (Q31 - beta2) * sq) >>> 31;
      if (nv > M31) nv = M31;
      mh = clamp32((nm * Q31) / (Q31 - p1));
      vh = (nv <<< 31) / (Q31 - p2);
      if (vh > M31) vh = M31;
      r = root_floor((eps + vh) <<< 24);
      mag = mh < 0 ? -mh : mh;
      // A zero root saturates the step in the sign of the corrected moment.
      if (r == 0) mag = (mag != 0) ? (64'sd1 <<< 33) : 0;
      else mag = (step * mag) / r;
      np = clamp32(mh < 0 ? pr - mag : pr + mag);
      u.m = nm[31:0];
      u.v = nv[30:0];
      u.param = np[31:0];
      u.nd1 = 31'((b1t * decay) >>> 31);
      u.np1 = 31'((p1 * beta1) >>> 31);
      u.np2 = 31'((p2 * beta2) >>> 31);
      u.last = e.last;
      pending.push_back(u);
    endfunction

    function void check(update_t got);
      update_t w;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result transfer with nothing outstanding");
        return;
      end
      w = pending.pop_front();
      if (got !== w) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: m %h/%h v %h/%h p %h/%h d1 %h/%h b1 %h/%h b2 %h/%h last %b/%b (exp/got)",
                   w.m, got.m, w.v, got.v, w.param, got.param, w.nd1, got.nd1,
                   w.np1, got.np1, w.np2, got.np2, w.last, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  aue_in_if  in_ch();
  aue_out_if out_ch();

  adam_update_element_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item(in_ch), .result(out_ch)
  );

  adam_scoreboard book;
  bit tx_calm, rx_calm, squeeze_go, squeeze_done;
  int idle_cycles;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int hold;
    update_t got;
    hold = 0;
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got.m = out_ch.new_first_moment;
        got.v = out_ch.new_second_moment;
        got.param = out_ch.new_param_value;
        got.nd1 = out_ch.next_decayed_beta_one;
        got.np1 = out_ch.next_beta_one_power;
        got.np2 = out_ch.next_beta_two_power;
        got.last = out_ch.last_out;
        book.check(got);
      end
      if (squeeze_go && !squeeze_done) begin
        squeeze_done = 1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
        if (!rx_calm && $urandom_range(0, 99) < 20)
          hold = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      end
    end
  end

  // Watchdog on cycles in which neither channel makes a transfer.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 4000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] data);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= data;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_STEP:  book.step = data[30:0];
      REG_BETA1: book.beta1 = data[30:0];
      REG_BETA2: book.beta2 = data[30:0];
      REG_DECAY: book.decay = data[30:0];
      REG_EPS:   book.eps = data[24:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [31:0] s, logic [31:0] b1, logic [31:0] b2,
                         logic [31:0] d, logic [31:0] e);
    reg_write(REG_STEP, s);
    reg_write(REG_BETA1, b1);
    reg_write(REG_BETA2, b2);
    reg_write(REG_DECAY, d);
    reg_write(REG_EPS, e);
  endtask

  task automatic send(element_t e);
    int gap;
    in_ch.valid <= 1;
    in_ch.gain_factor <= e.gain;
    in_ch.gradient <= e.grad;
    in_ch.first_moment <= e.m;
    in_ch.second_moment <= e.v;
    in_ch.param_value <= e.param;
    in_ch.decayed_beta_one <= e.b1t;
    in_ch.beta_one_power <= e.p1;
    in_ch.beta_two_power <= e.p2;
    in_ch.last_element <= e.last;
    do @(posedge clk); while (!in_ch.ready);
    book.note(e);
    gap = 0;
    if (!tx_calm) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
        6:       gap = $urandom_range(10, 50);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // The last element may still be offered, so withdraw it before waiting.
  task automatic drain();
    in_ch.valid <= 0;
    while (book.pending.size() != 0) @(posedge clk);
  endtask

  function automatic element_t mk(logic [31:0] g, logic [31:0] gr, logic [31:0] m,
                                  logic [30:0] v, logic [31:0] p, logic [30:0] b1t,
                                  logic [30:0] p1, logic [30:0] p2, logic last);
    element_t e;
    e.gain = g; e.grad = gr; e.m = m; e.v = v; e.param = p;
    e.b1t = b1t; e.p1 = p1; e.p2 = p2; e.last = last;
    return e;
  endfunction

  // Training-like element: gain near one, modest values, powers below one.
  function automatic element_t typical_element();
    return mk(32'sh0100_0000 + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000,
              $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000,
              $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000,
              31'($urandom_range(0, 32'h0100_0000)),
              $urandom,
              31'($urandom_range(32'h6000_0000, 32'h7FFF_FFFF)),
              31'($urandom_range(0, 32'h7FFF_FFFF)),
              31'($urandom_range(0, 32'h7FFF_FFFF)),
              ($urandom_range(0, 7) == 0));
  endfunction

  function automatic element_t wild_element();
    return mk($urandom, $urandom, $urandom, 31'($urandom), $urandom,
              31'($urandom), 31'($urandom), 31'($urandom), 1'($urandom_range(0, 1)));
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      send(($urandom_range(0, 9) < 7) ? typical_element() : wild_element());
    end
  endtask

  initial begin
    book = new();
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_ch.valid = 0;
    in_ch.gain_factor = 0; in_ch.gradient = 0; in_ch.first_moment = 0;
    in_ch.second_moment = 0; in_ch.param_value = 0; in_ch.decayed_beta_one = 0;
    in_ch.beta_one_power = 0; in_ch.beta_two_power = 0; in_ch.last_element = 0;
    tx_calm = 0; rx_calm = 0; squeeze_go = 0; squeeze_done = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed elements under the reset settings.
    send(mk(32'sh0100_0000, 32'sh0010_0000, 0, 0, 0, 31'h7333_3333, 31'h7333_3333,
            31'h7FDF_3B64, 1));
    send(mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, MAX31, 32'sh7FFF_FFFF,
            MAX31, MAX31, MAX31, 0));
    send(mk(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, MAX31, 32'sh8000_0000,
            MAX31, 0, 0, 1));
    send(mk(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0,
            MAX31, 0, 0));
    send(mk(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh8000_0000, 0, 0,
            MAX31, 1));
    send(mk(0, 0, 0, 0, 32'sh1234_5678, 31'h4000_0000, 31'h4000_0000, 31'h4000_0000, 0));
    send(mk(32'sh0100_0000, 32'shFF00_0000, 32'sh0000_1000, 31'h10, 0, 31'h7000_0000,
            31'h100, 31'h100, 0));
    send(mk(32'sh0001_0000, 32'sh0001_0000, 32'shFFFF_0000, 31'h0000_0001, 32'sh7FFF_FF00,
            31'h1, 31'h7FFF_FFFE, 31'h7FFF_FFFE, 1));
    drain();

    // A zero epsilon with zero second moment gives a zero root.
    set_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send(mk(0, 0, 32'sh0100_0000, 0, 32'sh0000_0100, 31'h7FFF_FFFF, 0, 0, 0));
    send(mk(0, 0, 32'shFF00_0000, 0, 32'shFFFF_0000, 31'h7FFF_FFFF, 0, 0, 1));
    send(mk(0, 0, 0, 0, 32'sh0123_4567, 31'h7FFF_FFFF, 31'h100, 0, 0));
    send(mk(32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0100, 0, 0, 31'h7FFF_FFFF, 0, 0, 1));
    send(mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, MAX31, 32'sh7FFF_FFFF,
            MAX31, MAX31, MAX31, 0));
    drain();

    set_all(0, 0, 0, 0, 32'h01FF_FFFF);
    send(mk(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, MAX31, 32'sh8000_0000,
            MAX31, MAX31, MAX31, 1));
    send(mk(32'sh0100_0000, 32'sh0100_0000, 32'sh0100_0000, 31'h0100_0000, 0,
            31'h4000_0000, 31'h4000_0000, 31'h4000_0000, 0));
    random_phase(100);
    drain();

    // Reset-like settings with a long result hold-off while input keeps coming.
    set_all(32'(RST_STEP), 32'(RST_BETA1), 32'(RST_BETA2), 32'(RST_DECAY), 32'(RST_EPS));
    tx_calm = 1;
    squeeze_go <= 1;
    for (int i = 0; i < 250; i++)
      send(($urandom_range(0, 9) < 7) ? typical_element() : wild_element());
    drain();

    set_all($urandom, $urandom, $urandom, $urandom, $urandom);
    random_phase(130);
    drain();

    set_all(32'h0100_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    random_phase(150);
    drain();

    repeat (200) @(posedge clk);
    if (book.errors == 0 && book.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
